// ===== hdl/cpci_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpci_pkg
// Shared widths, CV constant table and divider result type for the
// calibrated pitch to CV interpolator.
// ----------------------------------------------------------------------------
package cpci_pkg;

  localparam int CAL_POINTS_DEF = 40;
  localparam int FREQ_W         = 23;
  localparam int CV_W           = 16;
  localparam int CV_SEL_W       = 7;
  localparam int CV_TABLE_SIZE  = 40;

  // arithmetic widths: dy * (f - x1), then 2*num + den
  localparam int DY_W    = CV_W + 1;
  localparam int DF_W    = FREQ_W + 1;
  localparam int PROD_W  = DY_W + DF_W;
  localparam int ADJ_W   = PROD_W + 1;
  localparam int NUM_W   = ADJ_W + 1;
  localparam int DEN_W   = FREQ_W + 1;
  localparam int DIV_Q_W = 18;
  localparam int SUM_W   = CV_W + 4;

  localparam logic signed [CV_W-1:0] CV_AT_ZERO = -16'sd6554;
  localparam logic signed [CV_W-1:0] CV_MAX     = 16'sd32767;
  localparam logic signed [CV_W-1:0] CV_MIN     = -16'sd32768;

  localparam logic signed [CV_W-1:0] CV_TABLE [CV_TABLE_SIZE] = '{
    -16'sd6554, -16'sd5734, -16'sd5325, -16'sd4506, -16'sd3686,
    -16'sd3277, -16'sd2458, -16'sd1638, -16'sd819,  -16'sd410,
    16'sd410,   16'sd1229,  16'sd1638,  16'sd2458,  16'sd3277,
    16'sd3686,  16'sd4506,  16'sd5325,  16'sd5734,  16'sd6554,
    16'sd7373,  16'sd8192,  16'sd8602,  16'sd9421,  16'sd10240,
    16'sd10650, 16'sd11469, 16'sd12288, 16'sd12698, 16'sd13517,
    16'sd14336, 16'sd14746, 16'sd15565, 16'sd16384, 16'sd17203,
    16'sd17613, 16'sd18432, 16'sd19251, 16'sd19661, 16'sd20480
  };

  typedef struct packed {
    logic                        done;
    logic                        ovf;
    logic                        neg;
    logic signed [DIV_Q_W:0]     quo;
  } div_res_t;

  // CV constant for a table index, clamped at the last entry
  function automatic logic signed [CV_W-1:0] cv_entry(input logic [CV_SEL_W-1:0] i);
    logic [5:0] sel;
    sel = i[5:0];
    if (i >= CV_SEL_W'(CV_TABLE_SIZE - 1)) begin
      return CV_TABLE[CV_TABLE_SIZE-1];
    end
    return CV_TABLE[sel];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/cpci_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpci_cell
// One calibration table cell: holds a stored frequency and takes its
// neighbor's word when the row shifts.
// ----------------------------------------------------------------------------
module cpci_cell (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [cpci_pkg::FREQ_W-1:0] d,
  output logic      [cpci_pkg::FREQ_W-1:0] q
);
  import cpci_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cpci_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpci_chain
// Row of table cells. Each shift moves every word one cell toward the head;
// the tail takes shift_in. Feeding the head back rotates the row.
// ----------------------------------------------------------------------------
module cpci_chain #(
  parameter int CAL_POINTS = cpci_pkg::CAL_POINTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        shift_en,
  input  wire logic [cpci_pkg::FREQ_W-1:0] shift_in,
  output logic      [cpci_pkg::FREQ_W-1:0] head
);
  import cpci_pkg::*;

  logic [FREQ_W-1:0] cell_q [CAL_POINTS];

  for (genvar k = 0; k < CAL_POINTS; k++) begin : g_cell
    logic [FREQ_W-1:0] cell_d;
    if (k == CAL_POINTS - 1) begin : g_tail
      assign cell_d = shift_in;
    end else begin : g_body
      assign cell_d = cell_q[k+1];
    end
    cpci_cell u_cell (
      .clk (clk),
      .en  (shift_en),
      .d   (cell_d),
      .q   (cell_q[k])
    );
  end

  assign head = cell_q[0];

endmodule
`default_nettype wire

// ===== hdl/cpci_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpci_div
// Radix-2 restoring divider giving floor(num / den) for den > 0. Quotients
// too large for the result range are flagged as overflow after one check.
// ----------------------------------------------------------------------------
module cpci_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [cpci_pkg::NUM_W-1:0] num,
  input  wire logic        [cpci_pkg::DEN_W-1:0] den,
  output cpci_pkg::div_res_t                     res
);
  import cpci_pkg::*;

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_CHK  = 2'd1;
  localparam logic [1:0] D_ITER = 2'd2;
  localparam logic [1:0] D_FIN  = 2'd3;
  localparam int CNT_W = $clog2(DIV_Q_W + 1);

  logic [1:0]         phase;
  logic [NUM_W-1:0]   rem;
  logic [NUM_W-1:0]   dsh;
  logic [DIV_Q_W-1:0] quo;
  logic [CNT_W-1:0]   cnt;
  logic               neg;
  logic [NUM_W-1:0]   num_neg;
  logic [DIV_Q_W:0]   quo_up;

  assign num_neg = NUM_W'(-num);
  assign quo_up  = {1'b0, quo} + (DIV_Q_W + 1)'(rem != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= D_IDLE;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      case (phase)
        D_IDLE: begin
          if (start) begin
            rem   <= num[NUM_W-1] ? num_neg : NUM_W'(num);
            neg   <= num[NUM_W-1];
            dsh   <= NUM_W'(den) << DIV_Q_W;
            quo   <= '0;
            phase <= D_CHK;
          end
        end
        D_CHK: begin
          // quotient wider than the result range: saturate, skip the steps
          if (rem >= dsh) begin
            res.ovf  <= 1'b1;
            res.neg  <= neg;
            res.quo  <= '0;
            res.done <= 1'b1;
            phase    <= D_IDLE;
          end else begin
            dsh   <= dsh >> 1;
            cnt   <= CNT_W'(DIV_Q_W);
            phase <= D_ITER;
          end
        end
        D_ITER: begin
          if (rem >= dsh) begin
            rem <= rem - dsh;
            quo <= {quo[DIV_Q_W-2:0], 1'b1};
          end else begin
            quo <= {quo[DIV_Q_W-2:0], 1'b0};
          end
          dsh <= dsh >> 1;
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            phase <= D_FIN;
          end
        end
        D_FIN: begin
          // floor for a negative numerator: round the magnitude up
          res.ovf  <= 1'b0;
          res.neg  <= neg;
          res.quo  <= neg ? $signed(-quo_up) : $signed({1'b0, quo});
          res.done <= 1'b1;
          phase    <= D_IDLE;
        end
        default: begin
          phase <= D_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/calibrated_pitch_to_cv_interpolator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calibrated_pitch_to_cv_interpolator
// Builds a frequency calibration table, then maps target frequencies to
// control voltages by piecewise linear interpolation over that table.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                        | tuser
//  --------+-----+------------------------------+---------------------------
//  s_*     | in  | [22:0] frequency, Q15.8 Hz   | [0] mode (1 = query)
//  m_*     | out | [15:0] cv, signed Q3.12 V    | [0] calibrated
//
//  Calibration words, and queries that arrive before calibration is done,
//  go straight to the output register. A query after calibration takes
//  one full rotation of the cell row to find the segment, then a
//  multiply, operand preparation and an 18-step restoring division.
//  One word is in flight at a time; a finished result waits in the output
//  register and the next word is taken as soon as that register is loaded.
//  rst is synchronous; the table cells hold no reset value.
//
module calibrated_pitch_to_cv_interpolator #(
  parameter int CAL_POINTS = cpci_pkg::CAL_POINTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [22:0] frequency
  input  wire logic [0:0]  s_tuser,   // [0] mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [15:0] cv
  output logic [0:0]       m_tuser    // [0] calibrated
);
  import cpci_pkg::*;

  localparam int IDX_W = $clog2(CAL_POINTS);
  localparam int CNT_W = $clog2(CAL_POINTS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]              state;
  logic [CNT_W-1:0]        cal_index;
  logic                    done_flag;
  logic signed [CV_W-1:0]  held_cv;

  // scan / arithmetic payload
  logic [FREQ_W-1:0]       fq;
  logic [IDX_W-1:0]        scan_k;
  logic                    found;
  logic [IDX_W-1:0]        seg;
  logic [FREQ_W-1:0]       prev;
  logic [FREQ_W-1:0]       x1;
  logic [FREQ_W-1:0]       x2;
  logic signed [CV_W-1:0]  y1;
  logic signed [PROD_W-1:0] prod;
  logic signed [DEN_W-1:0] den;
  logic signed [ADJ_W-1:0] num_adj;
  logic [FREQ_W-1:0]       dabs;
  logic signed [NUM_W-1:0] n_sum;
  logic [DEN_W-1:0]        d_div;
  logic                    div_start;
  div_res_t                div_res;

  // combinational helpers
  logic                    accept;
  logic                    in_mode;
  logic [FREQ_W-1:0]       in_freq;
  logic                    cal_full;
  logic                    cal_write;
  logic [FREQ_W-1:0]       head;
  logic                    chain_en;
  logic [FREQ_W-1:0]       chain_in;
  logic [CV_SEL_W-1:0]     seg_hi;
  logic signed [CV_W-1:0]  y_lo;
  logic signed [CV_W-1:0]  y_hi;
  logic signed [DY_W-1:0]  dy;
  logic signed [DF_W-1:0]  df;
  logic signed [DEN_W-1:0] den_neg;
  logic signed [SUM_W-1:0] cv_sum;
  logic signed [CV_W-1:0]  cv_sat;
  logic                    out_free;

  assign in_mode  = s_tuser[0];
  assign in_freq  = s_tdata[FREQ_W-1:0];
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign cal_full = (cal_index == CNT_W'(CAL_POINTS));
  assign cal_write = accept && !in_mode && !done_flag && !cal_full;
  assign out_free = !m_tvalid || m_tready;

  // calibration shifts the word in at the tail; a scan rotates the row
  assign chain_en = cal_write || (state == S_SCAN);
  assign chain_in = (state == S_SCAN) ? head : in_freq;

  cpci_chain #(
    .CAL_POINTS (CAL_POINTS)
  ) u_chain (
    .clk      (clk),
    .shift_en (chain_en),
    .shift_in (chain_in),
    .head     (head)
  );

  // segment endpoints and differences
  assign seg_hi = CV_SEL_W'(seg);
  assign y_hi   = cv_entry(seg_hi);
  assign y_lo   = cv_entry(seg_hi - CV_SEL_W'(1));
  assign dy     = DY_W'(y_hi) - DY_W'(y_lo);
  assign df     = $signed({1'b0, fq}) - $signed({1'b0, x1});
  assign den_neg = -den;

  // final add and saturate
  assign cv_sum = SUM_W'(y1) + SUM_W'(div_res.quo);
  always_comb begin
    if (div_res.ovf) begin
      cv_sat = div_res.neg ? CV_MIN : CV_MAX;
    end else if (cv_sum > SUM_W'(CV_MAX)) begin
      cv_sat = CV_MAX;
    end else if (cv_sum < SUM_W'(CV_MIN)) begin
      cv_sat = CV_MIN;
    end else begin
      cv_sat = CV_W'(cv_sum);
    end
  end

  cpci_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (n_sum),
    .den   (d_div),
    .res   (div_res)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cal_index <= '0;
      done_flag <= 1'b0;
      held_cv   <= CV_AT_ZERO;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!in_mode) begin
              if (!done_flag) begin
                if (!cal_full) begin
                  cal_index <= cal_index + CNT_W'(1);
                  held_cv   <= cv_entry(CV_SEL_W'(cal_index) + CV_SEL_W'(1));
                end else begin
                  // one more measurement after the table is full closes it
                  done_flag <= 1'b1;
                  cal_index <= '0;
                end
              end
              state <= S_OUT;
            end else if (done_flag) begin
              state <= S_SCAN;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_SCAN: begin
          if (scan_k == IDX_W'(CAL_POINTS - 1)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (seg == '0) begin
            held_cv <= CV_AT_ZERO;
            state   <= S_OUT;
          end else if (x1 == x2) begin
            held_cv <= y_lo;
            state   <= S_OUT;
          end else begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          state <= S_SUM;
        end
        S_SUM: begin
          div_start <= 1'b1;
          state     <= S_DIV;
        end
        S_DIV: begin
          if (div_res.done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          held_cv <= cv_sat;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // scan and arithmetic payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        fq     <= in_freq;
        scan_k <= '0;
        found  <= 1'b0;
      end
      S_SCAN: begin
        // head holds entry scan_k; the last entry catches targets above
        if (!found && ((head >= fq) || (scan_k == IDX_W'(CAL_POINTS - 1)))) begin
          found <= 1'b1;
          seg   <= scan_k;
          x1    <= prev;
          x2    <= head;
        end
        prev   <= head;
        scan_k <= scan_k + IDX_W'(1);
      end
      S_MUL: begin
        y1   <= y_lo;
        prod <= dy * df;
        den  <= $signed({1'b0, x2}) - $signed({1'b0, x1});
      end
      S_PREP: begin
        // fold the sign of the span into the numerator
        if (den[DEN_W-1]) begin
          num_adj <= -ADJ_W'(prod);
          dabs    <= den_neg[FREQ_W-1:0];
        end else begin
          num_adj <= ADJ_W'(prod);
          dabs    <= den[FREQ_W-1:0];
        end
      end
      S_SUM: begin
        // round to nearest: floor((2*num + den) / (2*den))
        n_sum <= $signed({num_adj, 1'b0}) + $signed({{(NUM_W-FREQ_W){1'b0}}, dabs});
        d_div <= {dabs, 1'b0};
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= held_cv;
        m_tuser  <= done_flag;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
